### hw/rtl/nrn_pkg.sv
`timescale 1ns / 1ps

package nrn_pkg;

	// Output geometry and fixed-point format.
	localparam int OUT_HEIGHT  = 48;
	localparam int OUT_WIDTH   = 320;
	localparam int MAX_SRC_DIM = 4096;
	localparam int FRAC_BITS   = 14;

	// Field widths.
	localparam int PIX_W     = 8;
	localparam int VAL_W     = 16;
	localparam int DIM_W     = 13;
	localparam int CNT_W     = 12;
	localparam int CH_W      = 3;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 9;
	localparam int CFG_IDX_W = 2;

	// Used output width holds up to OUT_WIDTH itself.
	localparam int RW_W      = $clog2(OUT_WIDTH + 1);
	// Column numerator c*rw + w - 1 and row numerator r*48 + h - 1.
	localparam int COL_NUM_W = $clog2(MAX_SRC_DIM * (OUT_WIDTH + 1));
	localparam int ROW_NUM_W = $clog2(MAX_SRC_DIM * (OUT_HEIGHT + 1));
	// Product of a column quotient and the source width.
	localparam int PCOL_W    = COL_W + DIM_W;
	// One divider step per quotient bit.
	localparam int DIV_STEPS = COL_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS = 2'd2;

	// Channel count codes that change the channel routing.
	localparam logic [CH_W-1:0] CH_GRAY = 3'd1;
	localparam logic [CH_W-1:0] CH_TWO  = 3'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_CMP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic hit;
		logic last_row;
		logic out_free;
	} dp_stat_t;

	// Normalization table: round((2p - 255) * 2^FRAC_BITS / 255) per byte value.
	typedef logic [255:0][VAL_W-1:0] norm_tab_t;

	function automatic norm_tab_t build_norm_tab();
		norm_tab_t t;
		int mag;
		int q;
		for (int p = 0; p < 256; p++) begin
			mag = (2 * p >= 255) ? (2 * p - 255) : (255 - 2 * p);
			q = ((mag << FRAC_BITS) * 2 + 255) / 510;
			t[p] = (2 * p < 255) ? VAL_W'(-q) : VAL_W'(q);
		end
		return t;
	endfunction

	localparam norm_tab_t NORM_TAB = build_norm_tab();

endpackage

### hw/rtl/nrn_if.sv
`timescale 1ns / 1ps

// Source pixel channel.
interface nrn_pix_if;
	import nrn_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] chan0;
	logic [PIX_W-1:0] chan1;
	logic [PIX_W-1:0] chan2;

	modport source(output valid, output chan0, output chan1, output chan2, input ready);
	modport sink(input valid, input chan0, input chan1, input chan2, output ready);
endinterface

// Resized and normalized sample channel.
interface nrn_res_if;
	import nrn_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ROW_W-1:0]        out_row;
	logic [COL_W-1:0]        out_col;
	logic signed [VAL_W-1:0] val_first;
	logic signed [VAL_W-1:0] val_second;
	logic signed [VAL_W-1:0] val_third;
	logic                    last_of_run;

	modport source(output valid, output out_row, output out_col, output val_first,
		output val_second, output val_third, output last_of_run, input ready);
	modport sink(input valid, input out_row, input out_col, input val_first,
		input val_second, input val_third, input last_of_run, output ready);
endinterface

### hw/rtl/nrn_ctrl.sv
`timescale 1ns / 1ps

module nrn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nrn_pkg::dp_stat_t stat,
	output nrn_pkg::dp_cmd_t  cmd
);
	import nrn_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = stat.hit ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_row) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/nrn_datapath.sv
`timescale 1ns / 1ps

module nrn_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [nrn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nrn_pkg::DIM_W-1:0]         cfg_data,
	input  logic [nrn_pkg::PIX_W-1:0]         chan0,
	input  logic [nrn_pkg::PIX_W-1:0]         chan1,
	input  logic [nrn_pkg::PIX_W-1:0]         chan2,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic [nrn_pkg::ROW_W-1:0]         out_row,
	output logic [nrn_pkg::COL_W-1:0]         out_col,
	output logic signed [nrn_pkg::VAL_W-1:0]  val_first,
	output logic signed [nrn_pkg::VAL_W-1:0]  val_second,
	output logic signed [nrn_pkg::VAL_W-1:0]  val_third,
	output logic                              last_of_run,
	input  nrn_pkg::dp_cmd_t                  cmd,
	output nrn_pkg::dp_stat_t                 stat
);
	import nrn_pkg::*;

	// Configuration; width and height are stored already clamped to the legal range.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [RW_W-1:0]  rw_q;
	logic [CH_W-1:0]  chans_q;
	logic [DIM_W-1:0] cfg_dim;

	// Source position of the next pixel.
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;

	// Per-pixel work registers.
	logic [CNT_W-1:0]     c_q;
	logic [CNT_W-1:0]     r_q;
	logic [COL_NUM_W-1:0] crw_q;
	logic [ROW_NUM_W-1:0] r48_q;
	logic [COL_NUM_W-1:0] col_rem_q;
	logic [ROW_NUM_W-1:0] row_rem_q;
	logic [COL_W-1:0]     x0_q;
	logic [ROW_W-1:0]     y_q;
	logic [STEP_W-1:0]    k_q;
	logic [PCOL_W-1:0]    pcol_q;
	logic [ROW_NUM_W-1:0] acc_q;
	logic [VAL_W-1:0]     v0_q;
	logic [VAL_W-1:0]     v1_q;
	logic [VAL_W-1:0]     v2_q;

	logic [COL_NUM_W-1:0] crw;
	logic [ROW_NUM_W-1:0] r48;
	logic [COL_NUM_W-1:0] col_div;
	logic [ROW_NUM_W-1:0] row_div;
	logic                 col_ge;
	logic                 row_ge;
	logic                 row_active;
	logic [ROW_NUM_W-1:0] row_lim;
	logic [ROW_NUM_W-1:0] acc_nxt;
	logic [VAL_W-1:0]     n0;
	logic [VAL_W-1:0]     n1;
	logic [VAL_W-1:0]     n2;

	// Output register.
	logic                    out_valid_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [COL_W-1:0]        out_col_q;
	logic [VAL_W-1:0]        out_v0_q;
	logic [VAL_W-1:0]        out_v1_q;
	logic [VAL_W-1:0]        out_v2_q;
	logic                    out_last_q;
	logic                    out_free;

	// Clamp a written dimension to 1 .. MAX_SRC_DIM.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_dim = DIM_W'(1);
		end else if (cfg_data > DIM_W'(MAX_SRC_DIM)) begin
			cfg_dim = DIM_W'(MAX_SRC_DIM);
		end else begin
			cfg_dim = cfg_data;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(320);
			height_q <= DIM_W'(48);
			rw_q     <= RW_W'(320);
			chans_q  <= CH_W'(3);
		end else if (cfg_we) begin
			if (cfg_index == REG_SRC_WIDTH) begin
				width_q <= cfg_dim;
				rw_q    <= (cfg_dim < DIM_W'(OUT_WIDTH)) ? RW_W'(cfg_dim) : RW_W'(OUT_WIDTH);
			end else if (cfg_index == REG_SRC_HEIGHT) begin
				height_q <= cfg_dim;
			end else if (cfg_index == REG_SRC_CHANNELS) begin
				chans_q <= cfg_data[CH_W-1:0];
			end
		end
	end

	// Raster counters advance on every accepted pixel.
	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (col_inc >= width_q) begin
				col_q <= '0;
				row_q <= (row_inc >= height_q) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// Numerators for the first sampling column and row.
	assign crw = COL_NUM_W'(col_q) * COL_NUM_W'(rw_q);
	assign r48 = ROW_NUM_W'(row_q * OUT_HEIGHT);

	// Normalized channel values with routing by channel count.
	always_comb begin
		n0 = NORM_TAB[chan0];
		if (chans_q <= CH_GRAY) begin
			n1 = n0;
			n2 = n0;
		end else if (chans_q == CH_TWO) begin
			n1 = NORM_TAB[chan1];
			n2 = n1;
		end else begin
			n1 = NORM_TAB[chan1];
			n2 = NORM_TAB[chan2];
		end
	end

	// Restoring division, one quotient bit per step for the column, and for the row in the last ROW_W steps.
	assign col_div    = COL_NUM_W'({{(COL_NUM_W-DIM_W){1'b0}}, width_q} << k_q);
	assign row_div    = ROW_NUM_W'({{(ROW_NUM_W-DIM_W){1'b0}}, height_q} << k_q);
	assign col_ge     = col_rem_q >= col_div;
	assign row_active = k_q < STEP_W'(ROW_W);
	assign row_ge     = row_rem_q >= row_div;

	// Row emission limit and the next row product.
	assign row_lim = r48_q + ROW_NUM_W'(OUT_HEIGHT);
	assign acc_nxt = acc_q + ROW_NUM_W'(height_q);

	// Per-pixel work registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q       <= col_q;
			r_q       <= row_q;
			crw_q     <= crw;
			r48_q     <= r48;
			col_rem_q <= crw + COL_NUM_W'(width_q) - COL_NUM_W'(1);
			row_rem_q <= r48 + ROW_NUM_W'(height_q) - ROW_NUM_W'(1);
			x0_q      <= '0;
			y_q       <= '0;
			k_q       <= STEP_W'(DIV_STEPS - 1);
			v0_q      <= n0;
			v1_q      <= n1;
			v2_q      <= n2;
		end else if (cmd.div_step) begin
			x0_q <= {x0_q[COL_W-2:0], col_ge};
			if (col_ge) begin
				col_rem_q <= col_rem_q - col_div;
			end
			if (row_active) begin
				y_q <= {y_q[ROW_W-2:0], row_ge};
				if (row_ge) begin
					row_rem_q <= row_rem_q - row_div;
				end
			end
			k_q <= k_q - STEP_W'(1);
		end else if (cmd.mul) begin
			pcol_q <= PCOL_W'(x0_q) * PCOL_W'(width_q);
			acc_q  <= ROW_NUM_W'(y_q) * ROW_NUM_W'(height_q);
		end else if (cmd.emit) begin
			y_q   <= y_q + ROW_W'(1);
			acc_q <= acc_nxt;
		end
	end

	// Output register; it frees when the item is taken.
	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_row_q  <= y_q;
			out_col_q  <= x0_q;
			out_v0_q   <= v0_q;
			out_v1_q   <= v1_q;
			out_v2_q   <= v2_q;
			out_last_q <= stat.last_row;
		end
	end

	// Status to the controller.
	always_comb begin
		stat.div_last = (k_q == '0);
		stat.hit      = ({1'b0, c_q} < width_q) && (x0_q < rw_q)
			&& (pcol_q < PCOL_W'(crw_q) + PCOL_W'(rw_q))
			&& ({1'b0, r_q} < height_q) && (y_q < ROW_W'(OUT_HEIGHT))
			&& (acc_q < row_lim);
		stat.last_row = (y_q == ROW_W'(OUT_HEIGHT - 1)) || (acc_nxt >= row_lim);
		stat.out_free = out_free;
	end

	assign res_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign val_first   = out_v0_q;
	assign val_second  = out_v1_q;
	assign val_third   = out_v2_q;
	assign last_of_run = out_last_q;

`ifndef SYNTHESIS
	// A result is only written into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result written over a pending item");

	// Emitted rows stay inside the output height.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row_q < ROW_W'(OUT_HEIGHT)))
		else $error("output row out of range");

	// Emitted columns stay inside the used output width.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_col_q < rw_q))
		else $error("output column out of range");
`endif

endmodule

### hw/rtl/nearest_resize_normalize_core.sv
// Nearest-neighbor resize to a 48-row output with normalization to signed Q1.14.
// Source pixels enter in raster order on pix; for each pixel whose column is sampled
// by some output column, one item per sampling output row leaves on res in increasing
// row order, the final one flagged by last_of_run. A pixel passes through the accept,
// divide, multiply and compare states and then one emit state per result, which waits
// until the output register is free; the bit-serial divider finds the first output column
// and row for the pixel. The next pixel is taken while the last result still waits in the
// output register. Configuration is to be written only while the block is idle; the block
// does not enforce this, and a write does not reset the row and column counters.
`timescale 1ns / 1ps

module nearest_resize_normalize_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nrn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nrn_pkg::DIM_W-1:0]     cfg_data,
	nrn_pix_if.sink                       pix,
	nrn_res_if.source                     res
);
	import nrn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	assign pix.ready = in_ready;

	nrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nrn_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.chan0       (pix.chan0),
		.chan1       (pix.chan1),
		.chan2       (pix.chan2),
		.res_ready   (res.ready),
		.res_valid   (res.valid),
		.out_row     (res.out_row),
		.out_col     (res.out_col),
		.val_first   (res.val_first),
		.val_second  (res.val_second),
		.val_third   (res.val_third),
		.last_of_run (res.last_of_run),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule
